### rtl/thls_pkg.sv
// Shared types and constants of the three-axis homing and limit supervisor.
`timescale 1ns / 1ps
`default_nettype none

package thls_pkg;

    localparam int NUM_AXES    = 3;
    localparam int NUM_SLOTS   = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_HOME   = 3'd1;
    localparam logic [2:0] OP_LIMIT  = 3'd2;
    localparam logic [2:0] OP_ROTATE = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_STOP = 3'd1;
    localparam logic [2:0] ACT_VEL  = 3'd2;
    localparam logic [2:0] ACT_ZERO = 3'd3;
    localparam logic [2:0] ACT_REJ  = 3'd4;

    localparam logic [1:0] CFG_ORIGIN_LOW  = 2'd0;
    localparam logic [1:0] CFG_STOP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_STOP_LEVEL  = 2'd2;

    localparam logic [1:0]  AXIS_INVALID = 2'd3;
    localparam logic [10:0] SPEED_MAX    = 11'h7FF;
    localparam logic [11:0] SPEED_MIN    = 12'h800;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_L    = 2'd1,
        DIR_R    = 2'd2
    } dir_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [1:0]         axis;
        logic               direction;
        logic signed [11:0] speed;
        logic [2:0]         left_limits;
        logic [2:0]         right_limits;
        logic [2:0]         origin_levels;
        logic [2:0]         velocity_positive;
        logic [2:0]         velocity_negative;
        logic               stop_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         target_axis;
        logic [2:0]         action;
        logic signed [11:0] velocity;
        logic [2:0]         homed;
        logic               last;
    } out_item_t;

    // One motor command waiting to be sent.
    typedef struct packed {
        logic [1:0]         target_axis;
        logic [2:0]         action;
        logic signed [11:0] velocity;
    } slot_t;

    // All motor commands of one input item, in output order.
    typedef struct packed {
        slot_t [NUM_SLOTS-1:0] slots;
        logic [NUM_SLOTS-1:0]  mask;
        logic [2:0]            homed;
    } bundle_t;

endpackage

`default_nettype wire

### rtl/thls_front.sv
// Front part: accepts items, updates axis state and builds the command bundle.
`timescale 1ns / 1ps
`default_nettype none

module thls_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire thls_pkg::in_item_t in_item,
    input  wire logic               queue_full,
    output logic                    push,
    output thls_pkg::bundle_t       bundle
);

    logic origin_low_reg;
    logic stop_enable_reg;
    logic stop_level_reg;

    logic [thls_pkg::NUM_AXES-1:0] active_reg, active_next;
    logic [thls_pkg::NUM_AXES-1:0] done_reg, done_next;
    thls_pkg::dir_t                origin_dir_reg [thls_pkg::NUM_AXES];
    thls_pkg::dir_t                origin_dir_next [thls_pkg::NUM_AXES];
    thls_pkg::dir_t                limit_dir_reg [thls_pkg::NUM_AXES];
    thls_pkg::dir_t                limit_dir_next [thls_pkg::NUM_AXES];
    thls_pkg::dir_t                motion_dir_reg [thls_pkg::NUM_AXES];
    thls_pkg::dir_t                motion_dir_next [thls_pkg::NUM_AXES];
    logic [10:0]                   speed_reg [thls_pkg::NUM_AXES];
    logic [10:0]                   speed_next [thls_pkg::NUM_AXES];
    logic                          gstop_reg, gstop_next;

    logic        accept;
    logic        bad_axis;
    logic        rejected;
    logic [1:0]  ax;
    logic [10:0] mag;
    logic [11:0] home_vel;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;
    assign ax       = in_item.axis;
    assign bad_axis = (in_item.axis == thls_pkg::AXIS_INVALID);

    always_comb
    begin
        if (!in_item.speed[11])
        begin
            mag = in_item.speed[10:0];
        end
        else if (in_item.speed == thls_pkg::SPEED_MIN)
        begin
            mag = thls_pkg::SPEED_MAX;
        end
        else
        begin
            mag = 11'(-in_item.speed);
        end
    end

    assign home_vel = in_item.direction ? {1'b0, mag} : 12'(-{1'b0, mag});

    assign rejected = bad_axis
        || (in_item.operation != thls_pkg::OP_STOP && gstop_reg)
        || (in_item.operation == thls_pkg::OP_ROTATE && in_item.speed == thls_pkg::SPEED_MIN);

    always_comb
    begin
        logic        reached;
        logic [11:0] vel_pos;
        active_next     = active_reg;
        done_next       = done_reg;
        origin_dir_next = origin_dir_reg;
        limit_dir_next  = limit_dir_reg;
        motion_dir_next = motion_dir_reg;
        speed_next      = speed_reg;
        gstop_next      = gstop_reg;
        bundle          = '0;
        reached         = 1'b0;
        vel_pos         = '0;

        if (accept)
        begin
            if (in_item.operation == thls_pkg::OP_TICK)
            begin
                gstop_next = stop_enable_reg && (in_item.stop_level == stop_level_reg);
                if (gstop_next)
                begin
                    for (int i = 0; i < thls_pkg::NUM_AXES; i++)
                    begin
                        bundle.slots[i] = '{target_axis: 2'(i), action: thls_pkg::ACT_STOP,
                                            velocity: '0};
                        bundle.mask[i]  = 1'b1;
                    end
                end
                else
                begin
                    // Axes are independent; only the slot order ties them together.
                    for (int i = 0; i < thls_pkg::NUM_AXES; i++)
                    begin
                        vel_pos = {1'b0, speed_reg[i]};
                        if (in_item.left_limits[i])
                        begin
                            if (active_next[i])
                            begin
                                if (limit_dir_next[i] == thls_pkg::DIR_L)
                                begin
                                    active_next[i]     = 1'b0;
                                    done_next[i]       = 1'b1;
                                    origin_dir_next[i] = thls_pkg::DIR_IDLE;
                                    limit_dir_next[i]  = thls_pkg::DIR_IDLE;
                                    motion_dir_next[i] = thls_pkg::DIR_IDLE;
                                    bundle.slots[2*i]  = '{target_axis: 2'(i),
                                        action: thls_pkg::ACT_ZERO, velocity: '0};
                                end
                                else
                                begin
                                    motion_dir_next[i] = thls_pkg::DIR_R;
                                    bundle.slots[2*i]  = '{target_axis: 2'(i),
                                        action: thls_pkg::ACT_VEL, velocity: vel_pos};
                                end
                                bundle.mask[2*i] = 1'b1;
                            end
                            else if (motion_dir_next[i] == thls_pkg::DIR_L)
                            begin
                                motion_dir_next[i] = thls_pkg::DIR_IDLE;
                                bundle.slots[2*i]  = '{target_axis: 2'(i),
                                    action: thls_pkg::ACT_STOP, velocity: '0};
                                bundle.mask[2*i]   = 1'b1;
                            end
                        end
                        if (in_item.right_limits[i])
                        begin
                            if (active_next[i])
                            begin
                                if (limit_dir_next[i] == thls_pkg::DIR_R)
                                begin
                                    active_next[i]      = 1'b0;
                                    done_next[i]        = 1'b1;
                                    origin_dir_next[i]  = thls_pkg::DIR_IDLE;
                                    limit_dir_next[i]   = thls_pkg::DIR_IDLE;
                                    motion_dir_next[i]  = thls_pkg::DIR_IDLE;
                                    bundle.slots[2*i+1] = '{target_axis: 2'(i),
                                        action: thls_pkg::ACT_ZERO, velocity: '0};
                                end
                                else
                                begin
                                    motion_dir_next[i]  = thls_pkg::DIR_L;
                                    bundle.slots[2*i+1] = '{target_axis: 2'(i),
                                        action: thls_pkg::ACT_VEL, velocity: 12'(-vel_pos)};
                                end
                                bundle.mask[2*i+1] = 1'b1;
                            end
                            else if (motion_dir_next[i] == thls_pkg::DIR_R)
                            begin
                                motion_dir_next[i]  = thls_pkg::DIR_IDLE;
                                bundle.slots[2*i+1] = '{target_axis: 2'(i),
                                    action: thls_pkg::ACT_STOP, velocity: '0};
                                bundle.mask[2*i+1]  = 1'b1;
                            end
                        end
                        reached = origin_low_reg ? !in_item.origin_levels[i]
                                                 : in_item.origin_levels[i];
                        // The origin only counts when crossed while moving back.
                        if (active_next[i] && reached
                            && ((origin_dir_next[i] == thls_pkg::DIR_L
                                 && !in_item.velocity_negative[i]
                                 && in_item.velocity_positive[i])
                             || (origin_dir_next[i] == thls_pkg::DIR_R
                                 && in_item.velocity_negative[i])))
                        begin
                            active_next[i]      = 1'b0;
                            done_next[i]        = 1'b1;
                            origin_dir_next[i]  = thls_pkg::DIR_IDLE;
                            limit_dir_next[i]   = thls_pkg::DIR_IDLE;
                            motion_dir_next[i]  = thls_pkg::DIR_IDLE;
                            bundle.slots[6+i]   = '{target_axis: 2'(i),
                                action: thls_pkg::ACT_ZERO, velocity: '0};
                            bundle.mask[6+i]    = 1'b1;
                        end
                    end
                end
            end
            else if (in_item.operation <= thls_pkg::OP_STOP)
            begin
                if (rejected)
                begin
                    bundle.slots[0] = '{target_axis: bad_axis ? 2'd0 : ax,
                                        action: thls_pkg::ACT_REJ, velocity: '0};
                    bundle.mask[0]  = 1'b1;
                end
                else
                begin
                    unique case (in_item.operation)
                        thls_pkg::OP_HOME:
                        begin
                            done_next[ax]       = 1'b0;
                            active_next[ax]     = 1'b1;
                            origin_dir_next[ax] = in_item.direction ? thls_pkg::DIR_R
                                                                    : thls_pkg::DIR_L;
                            motion_dir_next[ax] = in_item.direction ? thls_pkg::DIR_R
                                                                    : thls_pkg::DIR_L;
                            speed_next[ax]      = mag;
                            bundle.slots[0] = '{target_axis: ax, action: thls_pkg::ACT_STOP,
                                                velocity: '0};
                            bundle.slots[1] = '{target_axis: ax, action: thls_pkg::ACT_VEL,
                                                velocity: home_vel};
                            bundle.mask[1:0] = 2'b11;
                        end
                        thls_pkg::OP_LIMIT:
                        begin
                            done_next[ax]       = 1'b0;
                            active_next[ax]     = 1'b1;
                            limit_dir_next[ax]  = in_item.direction ? thls_pkg::DIR_R
                                                                    : thls_pkg::DIR_L;
                            motion_dir_next[ax] = in_item.direction ? thls_pkg::DIR_R
                                                                    : thls_pkg::DIR_L;
                            speed_next[ax]      = mag;
                            bundle.slots[0] = '{target_axis: ax, action: thls_pkg::ACT_VEL,
                                                velocity: home_vel};
                            bundle.mask[0]  = 1'b1;
                        end
                        thls_pkg::OP_ROTATE:
                        begin
                            motion_dir_next[ax] = (!in_item.speed[11] && in_item.speed != '0)
                                                ? thls_pkg::DIR_R : thls_pkg::DIR_L;
                            bundle.slots[0] = '{target_axis: ax, action: thls_pkg::ACT_VEL,
                                                velocity: in_item.speed};
                            bundle.mask[0]  = 1'b1;
                        end
                        default:
                        begin
                            bundle.slots[0] = '{target_axis: ax, action: thls_pkg::ACT_STOP,
                                                velocity: '0};
                            bundle.mask[0]  = 1'b1;
                        end
                    endcase
                end
            end
            // An item with nothing to do still answers with one empty command.
            if (bundle.mask == '0)
            begin
                bundle.slots[0] = '{target_axis: 2'd0, action: thls_pkg::ACT_NONE,
                                    velocity: '0};
                bundle.mask[0]  = 1'b1;
            end
            bundle.homed = done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_low_reg  <= 1'b1;
            stop_enable_reg <= 1'b0;
            stop_level_reg  <= 1'b0;
            active_reg      <= '0;
            done_reg        <= '0;
            gstop_reg       <= 1'b0;
            for (int i = 0; i < thls_pkg::NUM_AXES; i++)
            begin
                origin_dir_reg[i] <= thls_pkg::DIR_IDLE;
                limit_dir_reg[i]  <= thls_pkg::DIR_IDLE;
                motion_dir_reg[i] <= thls_pkg::DIR_IDLE;
                speed_reg[i]      <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    thls_pkg::CFG_ORIGIN_LOW:  origin_low_reg  <= cfg_data;
                    thls_pkg::CFG_STOP_ENABLE: stop_enable_reg <= cfg_data;
                    thls_pkg::CFG_STOP_LEVEL:  stop_level_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            active_reg      <= active_next;
            done_reg        <= done_next;
            gstop_reg       <= gstop_next;
            origin_dir_reg  <= origin_dir_next;
            limit_dir_reg   <= limit_dir_next;
            motion_dir_reg  <= motion_dir_next;
            speed_reg       <= speed_next;
        end
    end

endmodule

`default_nettype wire

### rtl/thls_queue.sv
// Short queue of command bundles between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module thls_queue #(
    parameter int DEPTH = thls_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire thls_pkg::bundle_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output thls_pkg::bundle_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    thls_pkg::bundle_t store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/thls_back.sv
// Back part: sends bundle commands one per cycle unless stalled, via an output register.
`timescale 1ns / 1ps
`default_nettype none

module thls_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              not_empty,
    input  wire thls_pkg::bundle_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output thls_pkg::out_item_t    out_item
);

    logic [thls_pkg::NUM_SLOTS-1:0] sent_reg, sent_next;
    logic [thls_pkg::NUM_SLOTS-1:0] remaining;
    logic [thls_pkg::NUM_SLOTS-1:0] pick;
    logic                           out_valid_reg, out_valid_next;
    thls_pkg::out_item_t            out_item_reg, out_item_next;
    thls_pkg::slot_t                chosen;
    logic                           can_load;
    logic                           emit;
    logic                           final_cmd;

    assign remaining = head.mask & ~sent_reg;
    // Lowest remaining slot goes next.
    assign pick      = remaining & (~remaining + 1'b1);
    assign final_cmd = ((remaining & ~pick) == '0);
    assign can_load  = !out_valid_reg || !out_stall;
    assign emit      = can_load && not_empty;
    assign pop       = emit && final_cmd;

    always_comb
    begin
        chosen = '0;
        for (int k = 0; k < thls_pkg::NUM_SLOTS; k++)
        begin
            if (pick[k])
            begin
                chosen = chosen | head.slots[k];
            end
        end
    end

    always_comb
    begin
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (can_load)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            out_item_next = '{target_axis: chosen.target_axis, action: chosen.action,
                              velocity: chosen.velocity, homed: head.homed,
                              last: final_cmd};
            sent_next     = final_cmd ? '0 : (sent_reg | pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

### rtl/three_axis_homing_limit_supervisor_top.sv
// Top level of the three-axis homing and limit supervisor.
//
//  Port group            Direction  Handshake          Contents
//  in_valid/in_item      in         valid, in_stall    tick or axis command
//  out_valid/out_item    out        valid, out_stall   one motor command
//  cfg_we/cfg_index      in         write enable       register write, no read-back
//
// An input item is taken whenever the bundle queue has room; its
// commands are classified and the axis state updated in that same cycle.
// The back part sends one command per cycle while the output is not stalled; an item
// has one to nine results; the first result passes through the queue storage and
// the output register. Reset clears all axis state and loads the register defaults.
// A stalled output holds its command, the back part waits, and once the queue
// is full in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_homing_limit_supervisor_top #(
    parameter int QUEUE_DEPTH = thls_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic                cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire thls_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output thls_pkg::out_item_t      out_item
);

    logic              push;
    logic              full;
    logic              pop;
    logic              not_empty;
    thls_pkg::bundle_t push_data;
    thls_pkg::bundle_t head;

    thls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .queue_full (full),
        .push       (push),
        .bundle     (push_data)
    );

    thls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    thls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

### verif/three_axis_homing_limit_supervisor_top_test.sv
// Testbench for the three-axis homing and limit supervisor against predicted motor commands.
`timescale 1ns / 1ps

import thls_pkg::*;

// Tracks the axis state of the supervisor and holds the motor commands still to come.
class axis_command_predictor;
    logic org_low;
    logic stop_en;
    logic stop_lvl;
    logic [2:0] hunting;
    logic [2:0] done;
    dir_t org_dir [3];
    dir_t lim_dir [3];
    dir_t move_dir [3];
    logic [10:0] hspeed [3];
    logic halted;
    out_item_t batch [$];
    out_item_t awaited_cmds [$];
    int faults;

    function new();
        int i;
        org_low = 1'b1;
        stop_en = 1'b0;
        stop_lvl = 1'b0;
        hunting = '0;
        done = '0;
        halted = 1'b0;
        faults = 0;
        for (i = 0; i < NUM_AXES; i++)
        begin
            org_dir[i] = DIR_IDLE;
            lim_dir[i] = DIR_IDLE;
            move_dir[i] = DIR_IDLE;
            hspeed[i] = '0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic val);
        case (idx)
            CFG_ORIGIN_LOW: org_low = val;
            CFG_STOP_ENABLE: stop_en = val;
            CFG_STOP_LEVEL: stop_lvl = val;
            default: ;
        endcase
    endfunction

    function void emit(logic [1:0] ax, logic [2:0] act, logic signed [11:0] vel);
        out_item_t c;
        if (batch.size() >= NUM_SLOTS)
            return;
        c.target_axis = ax;
        c.action = act;
        c.velocity = vel;
        c.homed = '0;
        c.last = 1'b0;
        batch.push_back(c);
    endfunction

    function void zero_axis(int i);
        hunting[i] = 1'b0;
        done[i] = 1'b1;
        org_dir[i] = DIR_IDLE;
        lim_dir[i] = DIR_IDLE;
        move_dir[i] = DIR_IDLE;
        emit(2'(i), ACT_ZERO, '0);
    endfunction

    function void drive_axis(int i, logic right, logic [10:0] mag);
        logic signed [11:0] v;
        v = {1'b0, mag};
        if (right)
        begin
            move_dir[i] = DIR_R;
        end
        else
        begin
            move_dir[i] = DIR_L;
            v = -v;
        end
        emit(2'(i), ACT_VEL, v);
    endfunction

    function void run_tick(in_item_t it);
        int i;
        logic reached;
        logic neg;
        logic pos;
        halted = stop_en && (it.stop_level == stop_lvl);
        if (halted)
        begin
            for (i = 0; i < NUM_AXES; i++)
                emit(2'(i), ACT_STOP, '0);
            return;
        end
        for (i = 0; i < NUM_AXES; i++)
        begin
            if (it.left_limits[i])
            begin
                if (hunting[i])
                begin
                    if (lim_dir[i] == DIR_L)
                        zero_axis(i);
                    else
                        drive_axis(i, 1'b1, hspeed[i]);
                end
                else if (move_dir[i] == DIR_L)
                begin
                    move_dir[i] = DIR_IDLE;
                    emit(2'(i), ACT_STOP, '0);
                end
            end
            if (it.right_limits[i])
            begin
                if (hunting[i])
                begin
                    if (lim_dir[i] == DIR_R)
                        zero_axis(i);
                    else
                        drive_axis(i, 1'b0, hspeed[i]);
                end
                else if (move_dir[i] == DIR_R)
                begin
                    move_dir[i] = DIR_IDLE;
                    emit(2'(i), ACT_STOP, '0);
                end
            end
        end
        // The origin counts only when crossed against the search direction;
        // a negative velocity sign wins over a positive one.
        for (i = 0; i < NUM_AXES; i++)
        begin
            reached = org_low ? !it.origin_levels[i] : it.origin_levels[i];
            neg = it.velocity_negative[i];
            pos = it.velocity_positive[i];
            if (hunting[i] && reached)
            begin
                if (org_dir[i] == DIR_L)
                begin
                    if (!neg && pos)
                        zero_axis(i);
                end
                else if (org_dir[i] == DIR_R)
                begin
                    if (neg)
                        zero_axis(i);
                end
            end
        end
    endfunction

    function void take_item(in_item_t it);
        logic signed [11:0] spd;
        logic signed [11:0] neg_spd;
        logic [10:0] mag;
        int a;
        int k;
        batch.delete();
        spd = it.speed;
        neg_spd = -spd;
        if (it.speed == SPEED_MIN)
            mag = SPEED_MAX;
        else if (spd < 0)
            mag = neg_spd[10:0];
        else
            mag = spd[10:0];
        a = int'(it.axis);
        case (it.operation)
            OP_TICK: run_tick(it);
            OP_HOME, OP_LIMIT, OP_ROTATE, OP_STOP:
            begin
                if (it.axis == AXIS_INVALID)
                    emit('0, ACT_REJ, '0);
                else if ((it.operation != OP_STOP && halted)
                         || (it.operation == OP_ROTATE && it.speed == SPEED_MIN))
                    emit(it.axis, ACT_REJ, '0);
                else if (it.operation == OP_HOME)
                begin
                    done[a] = 1'b0;
                    hunting[a] = 1'b1;
                    org_dir[a] = it.direction ? DIR_R : DIR_L;
                    hspeed[a] = mag;
                    emit(it.axis, ACT_STOP, '0);
                    drive_axis(a, it.direction, mag);
                end
                else if (it.operation == OP_LIMIT)
                begin
                    done[a] = 1'b0;
                    hunting[a] = 1'b1;
                    lim_dir[a] = it.direction ? DIR_R : DIR_L;
                    hspeed[a] = mag;
                    drive_axis(a, it.direction, mag);
                end
                else if (it.operation == OP_ROTATE)
                begin
                    move_dir[a] = (spd > 0) ? DIR_R : DIR_L;
                    emit(it.axis, ACT_VEL, spd);
                end
                else
                begin
                    emit(it.axis, ACT_STOP, '0);
                end
            end
            default: ;
        endcase
        if (batch.size() == 0)
            emit('0, ACT_NONE, '0);
        for (k = 0; k < batch.size(); k++)
        begin
            batch[k].homed = done;
            batch[k].last = (k == batch.size() - 1);
            awaited_cmds.push_back(batch[k]);
        end
    endfunction

    function void compare_field(string field, logic signed [12:0] want, logic signed [12:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            faults++;
        end
    endfunction

    function void check_cmd(out_item_t got);
        out_item_t want;
        if (awaited_cmds.size() == 0)
        begin
            $error("unexpected motor command: axis %0d action %0d",
                   got.target_axis, got.action);
            faults++;
            return;
        end
        want = awaited_cmds.pop_front();
        compare_field("target_axis", want.target_axis, got.target_axis);
        compare_field("action", want.action, got.action);
        compare_field("velocity", $signed(want.velocity), $signed(got.velocity));
        compare_field("homed", want.homed, got.homed);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module three_axis_homing_limit_supervisor_top_test;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic cfg_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;

    axis_command_predictor cmd_model;
    int burst_left = 0;
    int unsigned cycle_count = 0;

    three_axis_homing_limit_supervisor_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Outputs and stall only move at the rising edge, so the falling edge sees them settled.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            cmd_model.check_cmd(out_item);
    end

    // Receiver: switches between free flow, light and heavy random stalls and long stall runs.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 70);
                default: out_stall <= ($urandom_range(0, 9) == 0) ? ~out_stall : out_stall;
            endcase
        end
    end

    function automatic in_item_t noise_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(in_item_t)-1:0];
    endfunction

    function automatic logic [2:0] some_bits(int pct);
        logic [2:0] b;
        int i;
        for (i = 0; i < 3; i++)
            b[i] = ($urandom_range(0, 99) < pct);
        return b;
    endfunction

    function automatic in_item_t command_item(logic [2:0] op, logic [1:0] ax, logic dir,
                                              logic signed [11:0] spd);
        in_item_t it;
        it = noise_item();
        it.operation = op;
        it.axis = ax;
        it.direction = dir;
        it.speed = spd;
        return it;
    endfunction

    function automatic in_item_t tick_item(logic [2:0] left, logic [2:0] right, logic [2:0] org,
                                           logic [2:0] vpos, logic [2:0] vneg, logic lvl);
        in_item_t it;
        it = noise_item();
        it.operation = OP_TICK;
        it.left_limits = left;
        it.right_limits = right;
        it.origin_levels = org;
        it.velocity_positive = vpos;
        it.velocity_negative = vneg;
        it.stop_level = lvl;
        return it;
    endfunction

    // Ticks lean toward the axis under test and keep the external stop mostly released.
    function automatic in_item_t random_tick(int focus);
        in_item_t it;
        it = noise_item();
        it.operation = OP_TICK;
        it.left_limits = some_bits(15);
        it.right_limits = some_bits(15);
        if ($urandom_range(0, 99) < 35)
        begin
            if ($urandom_range(0, 1) == 1)
                it.left_limits[focus] = 1'b1;
            else
                it.right_limits[focus] = 1'b1;
        end
        if (cmd_model.stop_en && $urandom_range(0, 9) != 0)
            it.stop_level = ~cmd_model.stop_lvl;
        return it;
    endfunction

    function automatic logic signed [11:0] random_speed();
        logic signed [11:0] full;
        full = {1'b0, SPEED_MAX};
        case ($urandom_range(0, 9))
            0: return SPEED_MIN;
            1: return '0;
            2: return full;
            3: return -full;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        cmd_model.take_item(it);
        burst_left--;
    endtask

    task automatic set_config(input logic org_low, input logic stop_en, input logic stop_lvl);
        logic [1:0] regs [3] = '{CFG_ORIGIN_LOW, CFG_STOP_ENABLE, CFG_STOP_LEVEL};
        logic vals [3];
        int k;
        vals[0] = org_low;
        vals[1] = stop_en;
        vals[2] = stop_lvl;
        for (k = 0; k < 3; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            @(posedge clk);
            cmd_model.write_reg(regs[k], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (cmd_model.awaited_cmds.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Most items are a command followed by ticks on the same axis, so searches run to the end.
    task automatic random_phase(input int n);
        int made;
        int pick;
        int ax;
        int ticks;
        logic [2:0] op;
        in_item_t it;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            ax = $urandom_range(0, 2);
            if (pick < 65)
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_HOME;
                    1: op = OP_LIMIT;
                    default: op = OP_ROTATE;
                endcase
                send_item(command_item(op, 2'(ax), 1'($urandom_range(0, 1)), random_speed()));
                ticks = $urandom_range(1, 6);
                repeat (ticks) send_item(random_tick(ax));
                made += ticks + 1;
            end
            else if (pick < 90)
            begin
                send_item(command_item(3'($urandom_range(1, 4)), 2'($urandom_range(0, 3)),
                                       1'($urandom_range(0, 1)), random_speed()));
                made++;
            end
            else
            begin
                it = noise_item();
                if (it.operation <= OP_STOP)
                    made++;
                send_item(it);
            end
        end
    endtask

    initial
    begin
        cmd_model = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ORIGIN_LOW;
        cfg_data <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: origin reached at pin level 0, no external stop.
        send_item(tick_item(3'b000, 3'b000, 3'b111, 3'b000, 3'b000, 1'b0));
        send_item(command_item(OP_ROTATE, 2'd0, 1'b0, {1'b0, SPEED_MAX}));
        send_item(tick_item(3'b000, 3'b001, 3'b111, 3'b000, 3'b000, 1'b0));
        send_item(command_item(OP_ROTATE, 2'd1, 1'b0, '0));
        send_item(tick_item(3'b010, 3'b000, 3'b111, 3'b000, 3'b000, 1'b0));
        send_item(command_item(OP_ROTATE, 2'd2, 1'b1, SPEED_MIN));
        send_item(command_item(OP_ROTATE, 2'd2, 1'b0, -{1'b0, SPEED_MAX}));
        send_item(command_item(OP_HOME, AXIS_INVALID, 1'b1, 12'sd10));
        // A homing speed of the most negative value saturates in magnitude.
        send_item(command_item(OP_HOME, 2'd0, 1'b1, SPEED_MIN));
        send_item(tick_item(3'b000, 3'b001, 3'b111, 3'b001, 3'b000, 1'b0));
        send_item(tick_item(3'b000, 3'b000, 3'b110, 3'b001, 3'b001, 1'b0));
        send_item(command_item(OP_LIMIT, 2'd1, 1'b0, 12'sd5));
        send_item(tick_item(3'b010, 3'b010, 3'b111, 3'b000, 3'b000, 1'b0));
        send_item(command_item(OP_LIMIT, 2'd2, 1'b1, {1'b0, SPEED_MAX}));
        send_item(tick_item(3'b100, 3'b000, 3'b111, 3'b000, 3'b000, 1'b0));
        send_item(tick_item(3'b000, 3'b100, 3'b111, 3'b000, 3'b000, 1'b0));
        send_item(command_item(OP_HOME, 2'd2, 1'b0, 12'sd100));
        // Both velocity signs set on a leftward search: the negative sign holds off the zero.
        send_item(tick_item(3'b000, 3'b000, 3'b011, 3'b100, 3'b100, 1'b0));
        send_item(tick_item(3'b000, 3'b000, 3'b011, 3'b100, 3'b000, 1'b0));
        send_item(command_item(OP_STOP, 2'd1, 1'b0, '0));
        send_item(command_item(OP_SPARE_LO, 2'd0, 1'b0, '0));
        send_item(command_item(OP_SPARE_HI, 2'd2, 1'b1, '0));
        send_item(command_item(OP_HOME, 2'd0, 1'b1, 12'sd300));
        send_item(command_item(OP_HOME, 2'd1, 1'b1, 12'sd300));
        send_item(command_item(OP_HOME, 2'd2, 1'b1, 12'sd300));
        // Both limits and the origin on every axis: the full nine commands.
        send_item(tick_item(3'b111, 3'b111, 3'b000, 3'b000, 3'b111, 1'b0));
        random_phase(65);
        settle(4);

        set_config(1'b0, 1'b1, 1'b1);
        send_item(tick_item(3'b000, 3'b000, 3'b000, 3'b000, 3'b000, 1'b1));
        send_item(command_item(OP_LIMIT, 2'd0, 1'b0, 12'sd50));
        send_item(command_item(OP_ROTATE, 2'd1, 1'b1, 12'sd20));
        send_item(command_item(OP_STOP, 2'd2, 1'b0, '0));
        send_item(tick_item(3'b000, 3'b000, 3'b000, 3'b000, 3'b000, 1'b0));
        random_phase(75);
        settle(4);

        set_config(1'b1, 1'b1, 1'b0);
        random_phase(75);
        settle(4);

        set_config(1'b0, 1'b0, 1'b1);
        random_phase(75);
        settle(10);

        if (cmd_model.faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
